// ----- rtl/dpbp_pkg.sv -----
// ----------------------------------------------------------------------------
// dpbp_pkg
// Shared widths, register map, reset values and types of the depth pixel
// back-projection core.
// ----------------------------------------------------------------------------
package dpbp_pkg;

	// input field widths
	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 16;

	// register widths
	localparam int CENTER_BITS = 16;
	localparam int RECIP_BITS  = 24;
	localparam int DATA_BITS   = 32;
	localparam int ADDR_BITS   = 5;
	localparam int OUT_BITS    = 32;

	// depth path: Z = (d * recip + 128) >> 8
	localparam int ZPROD_BITS = DEPTH_BITS + RECIP_BITS;
	localparam int Z_BITS     = ZPROD_BITS - 8;

	// lateral path widths
	localparam int POS_BITS   = COORD_BITS + 4;
	localparam int MAG_BITS   = (POS_BITS > CENTER_BITS) ? POS_BITS : CENTER_BITS;
	localparam int MPROD_BITS = MAG_BITS + RECIP_BITS;
	localparam int M_BITS     = MPROD_BITS - 12;
	localparam int P_BITS     = M_BITS + Z_BITS;
	localparam int R_BITS     = P_BITS - 16;

	// register map, index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_PRINCIPAL_X       = 3'd0,
		REG_PRINCIPAL_Y       = 3'd1,
		REG_INVERSE_FOCAL_X   = 3'd2,
		REG_INVERSE_FOCAL_Y   = 3'd3,
		REG_DEPTH_SCALE_RECIP = 3'd4
	} dpbp_reg_t;

	// reset values: default camera
	localparam logic [CENTER_BITS-1:0] RST_PRINCIPAL_X       = 16'd5098;
	localparam logic [CENTER_BITS-1:0] RST_PRINCIPAL_Y       = 16'd4085;
	localparam logic [RECIP_BITS-1:0]  RST_INVERSE_FOCAL_X   = 24'd32432;
	localparam logic [RECIP_BITS-1:0]  RST_INVERSE_FOCAL_Y   = 24'd32485;
	localparam logic [RECIP_BITS-1:0]  RST_DEPTH_SCALE_RECIP = 24'd3355;

	// configuration seen by the datapath
	typedef struct packed {
		logic [CENTER_BITS-1:0] principal_x;
		logic [CENTER_BITS-1:0] principal_y;
		logic [RECIP_BITS-1:0]  inverse_focal_x;
		logic [RECIP_BITS-1:0]  inverse_focal_y;
		logic [RECIP_BITS-1:0]  depth_scale_recip;
	} dpbp_cfg_t;

	// per-stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} dpbp_adv_t;

endpackage

// ----- rtl/dpbp_regs.sv -----
// ----------------------------------------------------------------------------
// dpbp_regs
// APB register file holding the camera intrinsics and depth scale.
// ----------------------------------------------------------------------------
module dpbp_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dpbp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [dpbp_pkg::DATA_BITS-1:0] pwdata,
	output logic [dpbp_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output dpbp_pkg::dpbp_cfg_t            cfg
);
	import dpbp_pkg::*;

	dpbp_cfg_t cfg_q;
	dpbp_reg_t idx;
	logic      wr_en;

	assign idx    = dpbp_reg_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.principal_x       <= RST_PRINCIPAL_X;
			cfg_q.principal_y       <= RST_PRINCIPAL_Y;
			cfg_q.inverse_focal_x   <= RST_INVERSE_FOCAL_X;
			cfg_q.inverse_focal_y   <= RST_INVERSE_FOCAL_Y;
			cfg_q.depth_scale_recip <= RST_DEPTH_SCALE_RECIP;
		end else if (wr_en) begin
			case (idx)
				REG_PRINCIPAL_X:       cfg_q.principal_x       <= pwdata[CENTER_BITS-1:0];
				REG_PRINCIPAL_Y:       cfg_q.principal_y       <= pwdata[CENTER_BITS-1:0];
				REG_INVERSE_FOCAL_X:   cfg_q.inverse_focal_x   <= pwdata[RECIP_BITS-1:0];
				REG_INVERSE_FOCAL_Y:   cfg_q.inverse_focal_y   <= pwdata[RECIP_BITS-1:0];
				REG_DEPTH_SCALE_RECIP: cfg_q.depth_scale_recip <= pwdata[RECIP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_PRINCIPAL_X:       prdata = DATA_BITS'(cfg_q.principal_x);
			REG_PRINCIPAL_Y:       prdata = DATA_BITS'(cfg_q.principal_y);
			REG_INVERSE_FOCAL_X:   prdata = DATA_BITS'(cfg_q.inverse_focal_x);
			REG_INVERSE_FOCAL_Y:   prdata = DATA_BITS'(cfg_q.inverse_focal_y);
			REG_DEPTH_SCALE_RECIP: prdata = DATA_BITS'(cfg_q.depth_scale_recip);
			default:               prdata = '0;
		endcase
	end

endmodule

// ----- rtl/dpbp_lateral.sv -----
// ----------------------------------------------------------------------------
// dpbp_lateral
// One lateral axis: offset from the principal point, scaling by the inverse
// focal length, multiplication by Z, rounding and saturation.
// ----------------------------------------------------------------------------
module dpbp_lateral (
	input  logic                             clk,
	input  dpbp_pkg::dpbp_adv_t              adv,
	input  logic [dpbp_pkg::COORD_BITS-1:0]  pix,
	input  logic [dpbp_pkg::CENTER_BITS-1:0] center,
	input  logic [dpbp_pkg::RECIP_BITS-1:0]  inv_focal,
	input  logic [dpbp_pkg::Z_BITS-1:0]      z_s3,
	output logic [dpbp_pkg::OUT_BITS-1:0]    coord_s5
);
	import dpbp_pkg::*;

	logic [MAG_BITS-1:0]   pos;
	logic [MAG_BITS-1:0]   ctr;
	logic                  neg_s1, neg_s2, neg_s3, neg_s4;
	logic [MAG_BITS-1:0]   mag_s1;
	logic [MPROD_BITS-1:0] mprod_s2;
	logic [MPROD_BITS-1:0] mround;
	logic [M_BITS-1:0]     m_s3;
	logic [P_BITS-1:0]     p_s4;
	logic [P_BITS-1:0]     pround;
	logic [R_BITS-1:0]     r;
	logic [OUT_BITS-1:0]   coord;

	// offset in sixteenths of a pixel, as sign and magnitude
	assign pos = MAG_BITS'({pix, 4'b0000});
	assign ctr = MAG_BITS'(center);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			neg_s1 <= pos < ctr;
			mag_s1 <= (pos < ctr) ? (ctr - pos) : (pos - ctr);
		end
	end

	// scale by the inverse focal length
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			neg_s2   <= neg_s1;
			mprod_s2 <= MPROD_BITS'(mag_s1) * MPROD_BITS'(inv_focal);
		end
	end

	// round to Q.16 (the add cannot carry out of the product width)
	assign mround = mprod_s2 + MPROD_BITS'(2048);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			neg_s3 <= neg_s2;
			m_s3   <= mround[MPROD_BITS-1:12];
		end
	end

	// multiply by unsaturated Z
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			neg_s4 <= neg_s3;
			p_s4   <= P_BITS'(m_s3) * P_BITS'(z_s3);
		end
	end

	// round half away from zero, apply sign and saturate
	assign pround = p_s4 + P_BITS'(32768);
	assign r      = pround[P_BITS-1:16];

	always_comb begin
		if (neg_s4) begin
			if (r > R_BITS'(33'h0_8000_0000))
				coord = 32'h8000_0000;
			else
				coord = 32'd0 - r[OUT_BITS-1:0];
		end else begin
			if (r > R_BITS'(32'h7FFF_FFFF))
				coord = 32'h7FFF_FFFF;
			else
				coord = r[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			coord_s5 <= coord;
		end
	end

endmodule

// ----- rtl/depth_pixel_backprojection_core.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_core
// Pinhole back-projection of a depth pixel stream to Q16.16 points.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   pixel   | pix_valid, pix_stall, depth_raw,         | in
//           | pixel_col, pixel_row                     |
//   point   | pt_valid, pt_stall, point_x, point_y,    | out
//           | point_z                                  |
//   config  | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
// One pixel is taken per clock while pix_stall is low; a point passes stages s1
// to s5, their number set by the two chained multiplies of the lateral path.
// Pixels with zero depth are dropped at the input and give no point.
// Reset clears the stage valid bits and loads the default camera.
// A stall on the point side freezes only the stages that hold an item;
// empty stages keep filling, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dpbp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [dpbp_pkg::DATA_BITS-1:0] pwdata,
	output logic [dpbp_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	// pixel in
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  logic [dpbp_pkg::DEPTH_BITS-1:0] depth_raw,
	input  logic [dpbp_pkg::COORD_BITS-1:0] pixel_col,
	input  logic [dpbp_pkg::COORD_BITS-1:0] pixel_row,
	// point out
	output logic                           pt_valid,
	input  logic                           pt_stall,
	output logic signed [dpbp_pkg::OUT_BITS-1:0] point_x,
	output logic signed [dpbp_pkg::OUT_BITS-1:0] point_y,
	output logic [dpbp_pkg::OUT_BITS-1:0]  point_z
);
	import dpbp_pkg::*;

	dpbp_cfg_t cfg;
	dpbp_adv_t adv;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ZPROD_BITS-1:0] zprod_s1;
	logic [ZPROD_BITS-1:0] zround;
	logic [Z_BITS-1:0]     z_s2, z_s3, z_s4, z_s5;
	logic [OUT_BITS-1:0]   x_s5, y_s5;

	// register file
	dpbp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// stage advance: a stage moves when empty or when the next one moves
	assign adv.s5    = !v_s5 || !pt_stall;
	assign adv.s4    = !v_s4 || adv.s5;
	assign adv.s3    = !v_s3 || adv.s4;
	assign adv.s2    = !v_s2 || adv.s3;
	assign adv.s1    = !v_s1 || adv.s2;
	assign pix_stall = !adv.s1;

	// valid bits, zero depth items never enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= pix_valid && (depth_raw != '0);
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	// depth times reciprocal scale
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			zprod_s1 <= ZPROD_BITS'(depth_raw) * ZPROD_BITS'(cfg.depth_scale_recip);
		end
	end

	// round to Q16.16; the product leaves headroom so no carry out
	assign zround = zprod_s1 + ZPROD_BITS'(128);

	always_ff @(posedge clk) begin
		if (adv.s2) z_s2 <= zround[ZPROD_BITS-1:8];
		if (adv.s3) z_s3 <= z_s2;
		if (adv.s4) z_s4 <= z_s3;
		if (adv.s5) z_s5 <= z_s4;
	end

	// lateral axes
	dpbp_lateral u_lat_x (
		.clk      (clk),
		.adv      (adv),
		.pix      (pixel_col),
		.center   (cfg.principal_x),
		.inv_focal(cfg.inverse_focal_x),
		.z_s3     (z_s3),
		.coord_s5 (x_s5)
	);

	dpbp_lateral u_lat_y (
		.clk      (clk),
		.adv      (adv),
		.pix      (pixel_row),
		.center   (cfg.principal_y),
		.inv_focal(cfg.inverse_focal_y),
		.z_s3     (z_s3),
		.coord_s5 (y_s5)
	);

	// outputs
	assign pt_valid = v_s5;
	assign point_x  = x_s5;
	assign point_y  = y_s5;
	assign point_z  = OUT_BITS'(z_s5);

endmodule
